// ===== src/scfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_pkg
// shared constants, phase encoding and the release record of the frame receiver
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] DIR_RESET = 8'h3C;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_M    = 3'd1,
        PH_DIR  = 3'd2,
        PH_LEN  = 3'd3,
        PH_CODE = 3'd4,
        PH_DATA = 3'd5,
        PH_CSUM = 3'd6
    } phase_t;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] code;
        logic [CNT_W-1:0]  len;
        logic              req;
    } scfr_release_t;

endpackage
`default_nettype wire

// ===== src/scfr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scfr channel interfaces
// valid/ready channels for received bytes and for released frame results
// ----------------------------------------------------------------------------
interface scfr_rx_if
    import scfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_res_if
    import scfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_code;
    logic [LEN_W-1:0]  frame_length;
    logic              is_request;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, output frame_code, output frame_length,
                    output is_request, output data_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input frame_code, input frame_length,
                    input is_request, input data_byte, input byte_index,
                    input last, output ready);
endinterface
`default_nettype wire

// ===== src/scfr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module scfr_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== src/scfr_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_parser
// header matching, checksum tracking and payload capture into the ram
// ----------------------------------------------------------------------------
module scfr_parser
    import scfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    scfr_rx_if.sink                rx,
    input  wire logic [BYTE_W-1:0] dir_char,
    input  wire logic              busy,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [BYTE_W-1:0]      wr_data,
    output scfr_release_t          rel
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] plen_reg, plen_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] taken_reg, taken_next;
    logic              req_reg, req_next;
    logic              accept;
    logic [BYTE_W-1:0] b;

    assign rx.ready = !busy;
    assign accept   = rx.valid && !busy;
    assign b        = rx.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            plen_reg  <= '0;
            code_reg  <= '0;
            xor_reg   <= '0;
            taken_reg <= '0;
            req_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            plen_reg  <= plen_next;
            code_reg  <= code_next;
            xor_reg   <= xor_next;
            taken_reg <= taken_next;
            req_reg   <= req_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        plen_next  = plen_reg;
        code_next  = code_reg;
        xor_next   = xor_reg;
        taken_next = taken_reg;
        req_next   = req_reg;
        wr_en      = 1'b0;
        wr_addr    = taken_reg[ADDR_W-1:0];
        wr_data    = b;
        rel.start  = 1'b0;
        rel.code   = code_reg;
        rel.len    = CNT_W'(plen_reg);
        rel.req    = req_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        plen_next  = '0;
                        code_next  = '0;
                        xor_next   = '0;
                        taken_next = '0;
                        req_next   = 1'b0;
                        phase_next = PH_M;
                    end
                end
                PH_M:
                begin
                    phase_next = (b == CH_M) ? PH_DIR : PH_IDLE;
                end
                PH_DIR:
                begin
                    phase_next = (b == dir_char) ? PH_LEN : PH_IDLE;
                end
                PH_LEN:
                begin
                    plen_next  = b;
                    req_next   = (b == '0);
                    phase_next = PH_CODE;
                end
                PH_CODE:
                begin
                    code_next  = b;
                    xor_next   = b ^ plen_reg;
                    taken_next = '0;
                    phase_next = req_reg ? PH_CSUM : PH_DATA;
                end
                PH_DATA:
                begin
                    // oversize payload still feeds the checksum, not the ram
                    wr_en      = (taken_reg < BYTE_W'(MAX_PAYLOAD));
                    xor_next   = xor_reg ^ b;
                    taken_next = taken_reg + 8'd1;
                    if (taken_next >= plen_reg)
                    begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    rel.start  = (b == xor_reg) && (plen_reg <= BYTE_W'(MAX_PAYLOAD));
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/scfr_readout.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scfr_readout
// walks the ram after a good checksum and drives the result channel
// ----------------------------------------------------------------------------
module scfr_readout
    import scfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scfr_release_t     rel,
    output logic                   busy,
    output logic                   rd_en,
    output logic [ADDR_W-1:0]      rd_addr,
    input  wire logic [BYTE_W-1:0] rd_data,
    scfr_res_if.source             res
);

    // control
    logic              act_reg, act_next;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic              pend_reg, pend_next;
    logic              ov_reg, ov_next;
    // frame record and pending read tags
    logic [BYTE_W-1:0] m_code_reg, m_code_next;
    logic [CNT_W-1:0]  m_len_reg, m_len_next;
    logic              m_req_reg, m_req_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              pend_last_reg, pend_last_next;
    // output register
    logic [BYTE_W-1:0] o_code_reg, o_code_next;
    logic [LEN_W-1:0]  o_len_reg, o_len_next;
    logic              o_req_reg, o_req_next;
    logic [BYTE_W-1:0] o_data_reg, o_data_next;
    logic [IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic              o_last_reg, o_last_next;

    logic out_free;
    logic load;
    logic issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            rd_cnt_reg <= '0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            act_reg    <= act_next;
            rd_cnt_reg <= rd_cnt_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_code_reg    <= m_code_next;
        m_len_reg     <= m_len_next;
        m_req_reg     <= m_req_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        o_code_reg    <= o_code_next;
        o_len_reg     <= o_len_next;
        o_req_reg     <= o_req_next;
        o_data_reg    <= o_data_next;
        o_idx_reg     <= o_idx_next;
        o_last_reg    <= o_last_next;
    end

    always_comb
    begin
        act_next       = act_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        ov_next        = ov_reg;
        m_code_next    = m_code_reg;
        m_len_next     = m_len_reg;
        m_req_next     = m_req_reg;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        o_code_next    = o_code_reg;
        o_len_next     = o_len_reg;
        o_req_next     = o_req_reg;
        o_data_next    = o_data_reg;
        o_idx_next     = o_idx_reg;
        o_last_next    = o_last_reg;
        out_free       = !ov_reg || res.ready;
        load           = 1'b0;
        issue          = 1'b0;

        if (res.ready)
        begin
            ov_next = 1'b0;
        end

        if (!act_reg)
        begin
            if (rel.start)
            begin
                act_next    = 1'b1;
                m_code_next = rel.code;
                m_len_next  = rel.len;
                m_req_next  = rel.req;
                rd_cnt_next = '0;
            end
        end
        else if (m_req_reg)
        begin
            // request frame: one result, no ram access
            if (out_free)
            begin
                ov_next     = 1'b1;
                o_code_next = m_code_reg;
                o_len_next  = '0;
                o_req_next  = 1'b1;
                o_data_next = '0;
                o_idx_next  = '0;
                o_last_next = 1'b1;
                act_next    = 1'b0;
            end
        end
        else
        begin
            load  = pend_reg && out_free;
            issue = (rd_cnt_reg < m_len_reg) && (!pend_reg || load);
            if (load)
            begin
                ov_next     = 1'b1;
                o_code_next = m_code_reg;
                o_len_next  = LEN_W'(m_len_reg);
                o_req_next  = 1'b0;
                o_data_next = rd_data;
                o_idx_next  = IDX_W'(pend_idx_reg);
                o_last_next = pend_last_reg;
                if (pend_last_reg)
                begin
                    act_next = 1'b0;
                end
            end
            if (issue)
            begin
                pend_next      = 1'b1;
                pend_idx_next  = rd_cnt_reg[ADDR_W-1:0];
                pend_last_next = ((rd_cnt_reg + CNT_W'(1)) == m_len_reg);
                rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
            end
            else if (load)
            begin
                pend_next = 1'b0;
            end
        end
    end

    assign busy    = act_reg;
    assign rd_en   = issue;
    assign rd_addr = rd_cnt_reg[ADDR_W-1:0];

    assign res.valid        = ov_reg;
    assign res.frame_code   = o_code_reg;
    assign res.frame_length = o_len_reg;
    assign res.is_request   = o_req_reg;
    assign res.data_byte    = o_data_reg;
    assign res.byte_index   = o_idx_reg;
    assign res.last         = o_last_reg;

endmodule
`default_nettype wire

// ===== src/serial_command_frame_receiver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_frame_receiver
// byte-stream frame receiver for '$' 'M' dir len code payload checksum frames
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer on rx and are taken one per cycle while
// the header, length, code and payload go by; payload bytes land in a
// 64-entry payload memory. When the checksum byte matches (xor of length,
// code and payload) and the length is within the memory, the frame is
// released on res: one transfer per payload byte with its index and a
// last flag on the final one, or a single transfer with is_request set for
// a zero-length frame. During release rx is held off: the memory's single
// read port delivers one byte per cycle while res is not stalled, and rx
// stays held until the last result is in the output register. Bad checksums
// and oversize frames are dropped without output. A header byte that does
// not match is consumed and the parser returns to hunting for '$'. The user
// must write direction_char (reset '<') through cfg_we/cfg_wdata only while
// the block is idle (not enforced). The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver
    import scfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    scfr_rx_if.sink                rx,
    scfr_res_if.source             res,
    input  wire logic              cfg_we,
    input  wire logic [BYTE_W-1:0] cfg_wdata
);

    // direction character register
    logic [BYTE_W-1:0] dir_reg;

    // parser to memory write port
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // readout to memory read port
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    // frame release handoff and interlock back to the parser
    scfr_release_t     rel;
    logic              busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_RESET;
        end
        else if (cfg_we)
        begin
            dir_reg <= cfg_wdata;
        end
    end

    // header, checksum and payload capture
    scfr_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .dir_char (dir_reg),
        .busy     (busy),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rel      (rel)
    );

    // payload memory
    scfr_ram #(
        .DEPTH (MAX_PAYLOAD),
        .WIDTH (BYTE_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // release sequencing and output register
    scfr_readout u_readout (
        .clk     (clk),
        .rst_n   (rst_n),
        .rel     (rel),
        .busy    (busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (res)
    );

    // a frame is only released while the readout is free
    a_rel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rel.start |-> !busy)
        else $error("frame released while readout active");

    // the memory is never written while a frame is being read out
    a_no_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy)
        else $error("payload write during readout");

    // a release always starts a readout
    a_rel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rel.start |=> busy)
        else $error("release did not start readout");

    // reads only happen during a readout
    a_rd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> busy)
        else $error("memory read outside readout");

endmodule
`default_nettype wire
